// File: rtl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// File: rtl/s16r_pkg.sv
// Shared constants, datapath codes and the sequencer-to-datapath control struct.
// Used by every module of the Spline16 window resampler; depends on nothing.
`default_nettype none

package s16r_pkg;

    localparam int FRAC_BITS_DEF   = 12;
    localparam int WEIGHT_BITS_DEF = 14;
    localparam int CH_W            = 8;
    localparam int POS_W           = 2;
    localparam int FRAC_IN_W       = 12;
    localparam int ACC_EXTRA       = 14;

    typedef enum logic [1:0] {
        A_CX,
        A_CY,
        A_XR,
        A_YR
    } a_sel_t;

    typedef enum logic [2:0] {
        B_AX,
        B_AY,
        B_RX,
        B_RY,
        B_YR,
        B_RED,
        B_GREEN,
        B_BLUE
    } b_sel_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_XP,
        ALU_YP,
        ALU_XU,
        ALU_YU,
        ALU_XW,
        ALU_YW,
        ALU_WRND,
        ALU_ACCR,
        ALU_ACCG,
        ALU_ACCB
    } alu_op_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        alu_op_t alu_op;
    } dp_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/s16r_seq.sv
// Step sequencer of the resampler: walks one tap through the shared multiplier.
// Depends on s16r_pkg for the datapath control struct and its codes.
`default_nettype none

module s16r_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               in_tap_valid,
    input  wire logic               in_last,
    input  wire logic               out_free,
    output logic                    in_ready,
    output logic                    out_load,
    output s16r_pkg::dp_ctrl_t      ctrl
);

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_X1   = 15'h0002,
        ST_Y1   = 15'h0004,
        ST_X2   = 15'h0008,
        ST_Y2   = 15'h0010,
        ST_X3   = 15'h0020,
        ST_Y3   = 15'h0040,
        ST_W1   = 15'h0080,
        ST_W2   = 15'h0100,
        ST_W3   = 15'h0200,
        ST_R    = 15'h0400,
        ST_G    = 15'h0800,
        ST_B    = 15'h1000,
        ST_ACC  = 15'h2000,
        ST_OUT  = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   last_reg;
    logic   last_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        out_load    = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.a_sel  = s16r_pkg::A_CX;
        ctrl.b_sel  = s16r_pkg::B_AX;
        ctrl.alu_op = s16r_pkg::ALU_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.load = 1'b1;
                    last_next = in_last;
                    priority if (in_tap_valid)
                    begin
                        state_next = ST_X1;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_X1:
            begin
                ctrl.a_sel = s16r_pkg::A_CX;
                ctrl.b_sel = s16r_pkg::B_AX;
                state_next = ST_Y1;
            end
            ST_Y1:
            begin
                ctrl.a_sel  = s16r_pkg::A_CY;
                ctrl.b_sel  = s16r_pkg::B_AY;
                ctrl.alu_op = s16r_pkg::ALU_XP;
                state_next  = ST_X2;
            end
            ST_X2:
            begin
                ctrl.a_sel  = s16r_pkg::A_XR;
                ctrl.b_sel  = s16r_pkg::B_AX;
                ctrl.alu_op = s16r_pkg::ALU_YP;
                state_next  = ST_Y2;
            end
            ST_Y2:
            begin
                ctrl.a_sel  = s16r_pkg::A_YR;
                ctrl.b_sel  = s16r_pkg::B_AY;
                ctrl.alu_op = s16r_pkg::ALU_XU;
                state_next  = ST_X3;
            end
            ST_X3:
            begin
                ctrl.a_sel  = s16r_pkg::A_XR;
                ctrl.b_sel  = s16r_pkg::B_RX;
                ctrl.alu_op = s16r_pkg::ALU_YU;
                state_next  = ST_Y3;
            end
            ST_Y3:
            begin
                ctrl.a_sel  = s16r_pkg::A_YR;
                ctrl.b_sel  = s16r_pkg::B_RY;
                ctrl.alu_op = s16r_pkg::ALU_XW;
                state_next  = ST_W1;
            end
            ST_W1:
            begin
                ctrl.alu_op = s16r_pkg::ALU_YW;
                state_next  = ST_W2;
            end
            ST_W2:
            begin
                ctrl.a_sel = s16r_pkg::A_XR;
                ctrl.b_sel = s16r_pkg::B_YR;
                state_next = ST_W3;
            end
            ST_W3:
            begin
                ctrl.alu_op = s16r_pkg::ALU_WRND;
                state_next  = ST_R;
            end
            ST_R:
            begin
                ctrl.a_sel = s16r_pkg::A_XR;
                ctrl.b_sel = s16r_pkg::B_RED;
                state_next = ST_G;
            end
            ST_G:
            begin
                ctrl.a_sel  = s16r_pkg::A_XR;
                ctrl.b_sel  = s16r_pkg::B_GREEN;
                ctrl.alu_op = s16r_pkg::ALU_ACCR;
                state_next  = ST_B;
            end
            ST_B:
            begin
                ctrl.a_sel  = s16r_pkg::A_XR;
                ctrl.b_sel  = s16r_pkg::B_BLUE;
                ctrl.alu_op = s16r_pkg::ALU_ACCG;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.alu_op = s16r_pkg::ALU_ACCB;
                state_next  = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ctrl.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/s16r_dp.sv
// Shared multiplier with its post-adder, work registers and the three channel sums.
// Depends on s16r_pkg; driven step by step by s16r_seq.
`default_nettype none

module s16r_dp #(
    parameter int FRAC_BITS   = s16r_pkg::FRAC_BITS_DEF,
    parameter int WEIGHT_BITS = s16r_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire s16r_pkg::dp_ctrl_t                    ctrl,
    input  wire logic [s16r_pkg::CH_W-1:0]             tap_red,
    input  wire logic [s16r_pkg::CH_W-1:0]             tap_green,
    input  wire logic [s16r_pkg::CH_W-1:0]             tap_blue,
    input  wire logic [s16r_pkg::POS_W-1:0]            tap_col,
    input  wire logic [s16r_pkg::POS_W-1:0]            tap_row,
    input  wire logic [s16r_pkg::FRAC_IN_W-1:0]        frac_x,
    input  wire logic [s16r_pkg::FRAC_IN_W-1:0]        frac_y,
    output logic signed [WEIGHT_BITS+s16r_pkg::ACC_EXTRA-1:0] sum_red,
    output logic signed [WEIGHT_BITS+s16r_pkg::ACC_EXTRA-1:0] sum_green,
    output logic signed [WEIGHT_BITS+s16r_pkg::ACC_EXTRA-1:0] sum_blue
);

    localparam int F     = FRAC_BITS;
    localparam int W     = WEIGHT_BITS;
    localparam int FU    = (F < s16r_pkg::FRAC_IN_W) ? F : s16r_pkg::FRAC_IN_W;
    localparam int AW    = F + 1;
    localparam int CW    = F + 5;
    localparam int XW    = (2 * F + 4 > W + 5) ? 2 * F + 4 : W + 5;
    localparam int BW    = (F + 2 > W + 7) ? F + 2 : W + 7;
    localparam int PW    = XW + BW;
    localparam int ACC_W = W + s16r_pkg::ACC_EXTRA;
    localparam int KSH   = 3 * F - W;
    localparam int SSH   = W + 8;

    localparam logic [63:0] ONE_SQ  = 64'd1 << (2 * F);
    localparam logic [63:0] ADD_IN  = (64'd5 << (3 * F)) + (64'd5 << (KSH - 1));
    localparam logic [63:0] ADD_OUT = 64'd15 << (KSH - 1);
    localparam logic [63:0] RCP_IN  = ((64'd1 << SSH) / 64'd5) + 64'd1;
    localparam logic [63:0] RCP_OUT = ((64'd1 << SSH) / 64'd15) + 64'd1;

    localparam logic [AW-1:0]        ONE_A      = AW'(64'd1 << F);
    localparam logic signed [CW-1:0] NINE_ONE   = CW'(64'd9 << F);
    localparam logic signed [CW-1:0] TWELVE_ONE = CW'(64'd12 << F);
    localparam logic signed [PW-1:0] K_IN       = PW'(ONE_SQ);
    localparam logic signed [PW-1:0] K_OUT      = PW'(64'd7 * ONE_SQ);
    localparam logic signed [PW-1:0] A_IN       = PW'(ADD_IN);
    localparam logic signed [PW-1:0] A_OUT      = PW'(ADD_OUT);
    localparam logic signed [PW-1:0] OFF_IN     = PW'(64'd5 << W);
    localparam logic signed [PW-1:0] OFF_OUT    = PW'(64'd15 << W);
    localparam logic signed [PW-1:0] ONE_W      = PW'(64'd1 << W);
    localparam logic signed [PW-1:0] HALF_W     = PW'(64'd1 << (W - 1));
    localparam logic signed [BW-1:0] R_IN       = BW'(RCP_IN);
    localparam logic signed [BW-1:0] R_OUT      = BW'(RCP_OUT);

    logic [s16r_pkg::CH_W-1:0] red_reg;
    logic [s16r_pkg::CH_W-1:0] green_reg;
    logic [s16r_pkg::CH_W-1:0] blue_reg;
    logic [AW-1:0]             ax_reg;
    logic [AW-1:0]             ay_reg;
    logic                      inx_reg;
    logic                      iny_reg;
    logic signed [CW-1:0]      cx_reg;
    logic signed [CW-1:0]      cy_reg;
    logic [AW-1:0]             ax_next;
    logic [AW-1:0]             ay_next;
    logic                      inx_next;
    logic                      iny_next;

    logic signed [XW-1:0]      a_op;
    logic signed [BW-1:0]      b_op;
    logic signed [PW-1:0]      prod_next;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      alu_res;
    logic                      sel_in;

    logic signed [XW-1:0]      xr_reg;
    logic signed [XW-1:0]      xr_next;
    logic signed [XW-1:0]      yr_reg;
    logic signed [XW-1:0]      yr_next;
    logic signed [ACC_W-1:0]   sum_red_reg;
    logic signed [ACC_W-1:0]   sum_red_next;
    logic signed [ACC_W-1:0]   sum_green_reg;
    logic signed [ACC_W-1:0]   sum_green_next;
    logic signed [ACC_W-1:0]   sum_blue_reg;
    logic signed [ACC_W-1:0]   sum_blue_next;

    // Kernel argument: t for the two taps before the position, one minus t after it.
    function automatic logic [AW-1:0] axis_arg(
        input logic [s16r_pkg::POS_W-1:0]     pos,
        input logic [s16r_pkg::FRAC_IN_W-1:0] frac
    );
        logic [AW-1:0] t;
        t = AW'(frac[FU-1:0]);
        if (pos[1])
        begin
            return ONE_A - t;
        end
        return t;
    endfunction

    // Leading Horner coefficient of the inner or outer cubic branch.
    function automatic logic signed [CW-1:0] axis_coef(
        input logic          inner,
        input logic [AW-1:0] a
    );
        logic signed [CW-1:0] a5;
        a5 = CW'({a, 2'b00}) + CW'(a);
        if (inner)
        begin
            return a5 - NINE_ONE;
        end
        return TWELVE_ONE - a5;
    endfunction

    assign ax_next  = axis_arg(tap_col, frac_x);
    assign ay_next  = axis_arg(tap_row, frac_y);
    assign inx_next = tap_col[0] ^ tap_col[1];
    assign iny_next = tap_row[0] ^ tap_row[1];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            red_reg   <= tap_red;
            green_reg <= tap_green;
            blue_reg  <= tap_blue;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            inx_reg   <= inx_next;
            iny_reg   <= iny_next;
            cx_reg    <= axis_coef(inx_next, ax_next);
            cy_reg    <= axis_coef(iny_next, ay_next);
        end
    end

    always_comb
    begin
        unique case (ctrl.a_sel)
            s16r_pkg::A_CX: a_op = XW'(cx_reg);
            s16r_pkg::A_CY: a_op = XW'(cy_reg);
            s16r_pkg::A_XR: a_op = xr_reg;
            s16r_pkg::A_YR: a_op = yr_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            s16r_pkg::B_AX:    b_op = BW'(ax_reg);
            s16r_pkg::B_AY:    b_op = BW'(ay_reg);
            s16r_pkg::B_RX:    b_op = inx_reg ? R_IN : R_OUT;
            s16r_pkg::B_RY:    b_op = iny_reg ? R_IN : R_OUT;
            s16r_pkg::B_YR:    b_op = BW'(yr_reg);
            s16r_pkg::B_RED:   b_op = BW'(red_reg);
            s16r_pkg::B_GREEN: b_op = BW'(green_reg);
            s16r_pkg::B_BLUE:  b_op = BW'(blue_reg);
        endcase
    end

    assign prod_next = PW'(a_op) * PW'(b_op);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_comb
    begin
        sel_in = iny_reg;
        if (ctrl.alu_op == s16r_pkg::ALU_XP || ctrl.alu_op == s16r_pkg::ALU_XU ||
            ctrl.alu_op == s16r_pkg::ALU_XW)
        begin
            sel_in = inx_reg;
        end
    end

    // Post-adder: cubic constant terms, division by 5 or 15 through the reciprocal,
    // weight rounding and accumulation all reuse the registered product.
    always_comb
    begin
        alu_res        = prod_reg;
        xr_next        = xr_reg;
        yr_next        = yr_reg;
        sum_red_next   = sum_red_reg;
        sum_green_next = sum_green_reg;
        sum_blue_next  = sum_blue_reg;
        unique case (ctrl.alu_op)
            s16r_pkg::ALU_XP, s16r_pkg::ALU_YP:
            begin
                alu_res = prod_reg - (sel_in ? K_IN : K_OUT);
            end
            s16r_pkg::ALU_XU, s16r_pkg::ALU_YU:
            begin
                alu_res = ((prod_reg + (sel_in ? A_IN : A_OUT)) >>> KSH) +
                          (sel_in ? OFF_IN : OFF_OUT);
            end
            s16r_pkg::ALU_XW, s16r_pkg::ALU_YW:
            begin
                alu_res = (prod_reg >>> SSH) - ONE_W;
            end
            s16r_pkg::ALU_WRND:
            begin
                alu_res = (prod_reg + HALF_W) >>> W;
            end
            s16r_pkg::ALU_ACCR:
            begin
                sum_red_next = sum_red_reg + ACC_W'(prod_reg);
            end
            s16r_pkg::ALU_ACCG:
            begin
                sum_green_next = sum_green_reg + ACC_W'(prod_reg);
            end
            s16r_pkg::ALU_ACCB:
            begin
                sum_blue_next = sum_blue_reg + ACC_W'(prod_reg);
            end
            default:
            begin
                alu_res = prod_reg;
            end
        endcase
        if (ctrl.alu_op == s16r_pkg::ALU_XP || ctrl.alu_op == s16r_pkg::ALU_XU ||
            ctrl.alu_op == s16r_pkg::ALU_XW || ctrl.alu_op == s16r_pkg::ALU_WRND)
        begin
            xr_next = XW'(alu_res);
        end
        if (ctrl.alu_op == s16r_pkg::ALU_YP || ctrl.alu_op == s16r_pkg::ALU_YU ||
            ctrl.alu_op == s16r_pkg::ALU_YW)
        begin
            yr_next = XW'(alu_res);
        end
    end

    always_ff @(posedge clk)
    begin
        xr_reg <= xr_next;
        yr_reg <= yr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
        end
        else
        begin
            sum_red_reg   <= sum_red_next;
            sum_green_reg <= sum_green_next;
            sum_blue_reg  <= sum_blue_next;
        end
    end

    assign sum_red   = sum_red_reg;
    assign sum_green = sum_green_reg;
    assign sum_blue  = sum_blue_reg;

endmodule

`default_nettype wire

// File: rtl/s16r_out.sv
// Result stage: rounds and clamps the three sums and holds the pixel for the master side.
// Depends on s16r_pkg for the channel width, the sum headroom and the default weight width.
`default_nettype none

module s16r_out #(
    parameter int WEIGHT_BITS = s16r_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        load,
    input  wire logic signed [WEIGHT_BITS+s16r_pkg::ACC_EXTRA-1:0] sum_red,
    input  wire logic signed [WEIGHT_BITS+s16r_pkg::ACC_EXTRA-1:0] sum_green,
    input  wire logic signed [WEIGHT_BITS+s16r_pkg::ACC_EXTRA-1:0] sum_blue,
    input  wire logic                                        tready,
    output logic                                             tvalid,
    output logic [3*s16r_pkg::CH_W-1:0]                      tdata,
    output logic                                             free
);

    localparam int W     = WEIGHT_BITS;
    localparam int ACC_W = W + s16r_pkg::ACC_EXTRA;
    localparam int VW    = ACC_W + 1;

    localparam logic signed [VW-1:0] HALF_V = VW'(64'd1 << (W - 1));
    localparam logic signed [VW-1:0] ZERO_V = '0;
    localparam logic signed [VW-1:0] MAX_V  = VW'(255);

    logic                              valid_reg;
    logic [3*s16r_pkg::CH_W-1:0]       data_reg;

    function automatic logic [s16r_pkg::CH_W-1:0] finish(
        input logic signed [ACC_W-1:0] s
    );
        logic signed [VW-1:0]      v;
        logic [s16r_pkg::CH_W-1:0] r;
        v = (VW'(s) + HALF_V) >>> W;
        priority if (v < ZERO_V)
        begin
            r = '0;
        end
        else if (v > MAX_V)
        begin
            r = '1;
        end
        else
        begin
            r = v[s16r_pkg::CH_W-1:0];
        end
        return r;
    endfunction

    assign free = !valid_reg || tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {finish(sum_blue), finish(sum_green), finish(sum_red)};
        end
    end

    assign tvalid = valid_reg;
    assign tdata  = data_reg;

endmodule

`default_nettype wire

// File: rtl/spline16_window_resampler.sv
// Spline16 window resampler, top level: builds one RGB pixel from the taps of a 4x4 window.
// Depends on s16r_pkg, s16r_seq, s16r_dp, s16r_out and assert_macros.svh.
//
// Taps arrive one item at a time on the slave side; tuser high marks a tap inside the
// frame and tlast marks the final tap of a window. Every valid tap is weighted with the
// Spline16 kernel from its own fractions and added to three signed sums; on the last tap
// the sums are rounded half up, clamped to 0..255 and sent as one pixel on the master
// side. All arithmetic runs through a single shared multiplier with a post-adder, so a
// valid tap is accepted and then walks thirteen sequencer steps for ten products, an
// invalid tap is only accepted, and the last tap of a window then moves the pixel into
// the output register, which waits while an earlier pixel is still held there.
`default_nettype none

`include "assert_macros.svh"

module spline16_window_resampler #(
    parameter int FRAC_BITS   = s16r_pkg::FRAC_BITS_DEF,
    parameter int WEIGHT_BITS = s16r_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tap_red, tap_green, tap_blue, tap_col, tap_row, frac_x, frac_y, zero fill
    input  wire logic [55:0] s_axis_tdata,
    // tap_valid
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]      m_axis_tdata
);

    localparam int ACC_W = WEIGHT_BITS + s16r_pkg::ACC_EXTRA;

    logic                     in_fire;
    logic                     out_free;
    logic                     out_load;
    s16r_pkg::dp_ctrl_t       ctrl;
    logic signed [ACC_W-1:0]  sum_red;
    logic signed [ACC_W-1:0]  sum_green;
    logic signed [ACC_W-1:0]  sum_blue;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    s16r_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_tap_valid (s_axis_tuser),
        .in_last      (s_axis_tlast),
        .out_free     (out_free),
        .in_ready     (s_axis_tready),
        .out_load     (out_load),
        .ctrl         (ctrl)
    );

    s16r_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .tap_red   (s_axis_tdata[7:0]),
        .tap_green (s_axis_tdata[15:8]),
        .tap_blue  (s_axis_tdata[23:16]),
        .tap_col   (s_axis_tdata[25:24]),
        .tap_row   (s_axis_tdata[27:26]),
        .frac_x    (s_axis_tdata[39:28]),
        .frac_y    (s_axis_tdata[51:40]),
        .sum_red   (sum_red),
        .sum_green (sum_green),
        .sum_blue  (sum_blue)
    );

    s16r_out #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .sum_red   (sum_red),
        .sum_green (sum_green),
        .sum_blue  (sum_blue),
        .tready    (m_axis_tready),
        .tvalid    (m_axis_tvalid),
        .tdata     (m_axis_tdata),
        .free      (out_free)
    );

    `ASSERT_NEVER(a_load_over_held, clk, rst_n, out_load && m_axis_tvalid && !m_axis_tready, "pixel loaded over a held result")
    `ASSERT_PROP(a_busy_after_valid_tap, clk, rst_n, (in_fire && s_axis_tuser) |=> !s_axis_tready, "ready stayed high after a valid tap")
    `ASSERT_PROP(a_load_sets_valid, clk, rst_n, out_load |=> m_axis_tvalid, "loaded pixel not offered")

endmodule

`default_nettype wire
